/* rtl/sdes_pkg.sv */
// Package with S-DES permutation tables, S-boxes and round-key helpers.
package sdes_pkg;

  localparam int unsigned KeyWidth   = 10;
  localparam int unsigned BlockWidth = 8;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [KeyWidth-1:0]   KeyReset = 10'd509;
  localparam logic [BlockWidth-1:0] IvReset  = 8'd170;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_CIPHER_KEY  = 2'd0,
    CFG_INIT_VECTOR = 2'd1,
    CFG_DIRECTION   = 2'd2
  } cfg_idx_e;

  // Bit positions counted from 1 at the MSB.
  localparam int P10Tab [10]  = '{3, 5, 2, 7, 4, 10, 1, 9, 8, 6};
  localparam int P8Tab [8]    = '{6, 3, 7, 4, 8, 5, 10, 9};
  localparam int IpTab [8]    = '{2, 6, 3, 1, 4, 8, 5, 7};
  localparam int IpInvTab [8] = '{4, 1, 3, 5, 7, 2, 8, 6};
  localparam int EpTab [8]    = '{4, 1, 2, 3, 2, 3, 4, 1};
  localparam int P4Tab [4]    = '{2, 4, 3, 1};

  // S-boxes, entry at row * 4 + column.
  localparam logic [1:0] S0Tab [16] = '{
    2'd1, 2'd0, 2'd3, 2'd2,
    2'd3, 2'd2, 2'd1, 2'd0,
    2'd0, 2'd2, 2'd1, 2'd3,
    2'd3, 2'd1, 2'd3, 2'd2
  };
  localparam logic [1:0] S1Tab [16] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd2, 2'd0, 2'd1, 2'd3,
    2'd3, 2'd0, 2'd1, 2'd0,
    2'd2, 2'd1, 2'd0, 2'd3
  };

  typedef struct packed {
    logic [BlockWidth-1:0] rk_one;
    logic [BlockWidth-1:0] rk_two;
  } round_keys_t;

  function automatic logic [9:0] perm_p10(logic [9:0] w);
    logic [9:0] r;
    for (int k = 0; k < 10; k++) r[9-k] = w[10-P10Tab[k]];
    return r;
  endfunction

  function automatic logic [7:0] perm_p8(logic [9:0] w);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[7-k] = w[10-P8Tab[k]];
    return r;
  endfunction

  function automatic logic [7:0] perm_ip(logic [7:0] w);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[7-k] = w[8-IpTab[k]];
    return r;
  endfunction

  function automatic logic [7:0] perm_ipinv(logic [7:0] w);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[7-k] = w[8-IpInvTab[k]];
    return r;
  endfunction

  function automatic logic [7:0] perm_ep(logic [3:0] w);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[7-k] = w[4-EpTab[k]];
    return r;
  endfunction

  function automatic logic [3:0] perm_p4(logic [3:0] w);
    logic [3:0] r;
    for (int k = 0; k < 4; k++) r[3-k] = w[4-P4Tab[k]];
    return r;
  endfunction

  function automatic logic [4:0] rot5(logic [4:0] v, int unsigned n);
    logic [9:0] d;
    d = {v, v} << n;
    return d[9:5];
  endfunction

  function automatic round_keys_t derive_keys(logic [KeyWidth-1:0] key);
    logic [9:0]  p;
    logic [4:0]  hi;
    logic [4:0]  lo;
    round_keys_t rk;
    p  = perm_p10(key);
    hi = rot5(p[9:5], 1);
    lo = rot5(p[4:0], 1);
    rk.rk_one = perm_p8({hi, lo});
    hi = rot5(hi, 2);
    lo = rot5(lo, 2);
    rk.rk_two = perm_p8({hi, lo});
    return rk;
  endfunction

  localparam round_keys_t RkReset = derive_keys(KeyReset);

  function automatic logic [3:0] round_fn(logic [3:0] half, logic [7:0] rk);
    logic [7:0] e;
    logic [1:0] s0;
    logic [1:0] s1;
    e  = perm_ep(half) ^ rk;
    s0 = S0Tab[{e[7], e[4], e[6:5]}];
    s1 = S1Tab[{e[3], e[0], e[2:1]}];
    return perm_p4({s0, s1});
  endfunction

  function automatic logic [7:0] sdes_block(logic [7:0] blk, logic [7:0] ka,
                                            logic [7:0] kb);
    logic [7:0] p;
    logic [3:0] nr;
    logic [3:0] nl;
    p  = perm_ip(blk);
    nr = p[7:4] ^ round_fn(p[3:0], ka);
    nl = p[3:0] ^ round_fn(nr, kb);
    return perm_ipinv({nl, nr});
  endfunction

endpackage

/* rtl/sdes_cbc_cipher_unit.sv */
// S-DES byte cipher in CBC mode with stream ports and a register write port.
// Each byte passes through the input register and then the result register before it is offered on the master side.
// Throughput: one byte per cycle while the master side accepts; the chain value closes through one S-DES pass.
// Reset: asynchronous, active low; key, IV, direction and chain take reset values.
// Round keys are rederived in the cycle of a key write.
module sdes_cbc_cipher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_wdata_i,
  // Slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_block
  input  logic        s_axis_tuser,   // [0] chain_restart
  // Master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [7:0] result_block
);

  // Configuration and derived state
  sdes_pkg::round_keys_t rk_q;
  logic [7:0]            iv_q;
  logic                  dir_q;
  logic [7:0]            chain_q;
  logic [7:0]            chain_d;

  // Input register
  logic       in_valid_q;
  logic [7:0] in_data_q;
  logic       in_restart_q;

  // Result register
  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic [7:0] out_data_d;

  logic       advance;
  logic       in_take;
  logic [7:0] prev_block;

  // Move the held item into the result register whenever that slot is free
  // or is being drained this cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Restart selects the IV as the previous block for this byte only.
  assign prev_block = in_restart_q ? iv_q : chain_q;

  always_comb begin
    if (!dir_q) begin
      // Encrypt: whiten with the chain, ciphertext feeds the chain.
      out_data_d = sdes_pkg::sdes_block(in_data_q ^ prev_block, rk_q.rk_one, rk_q.rk_two);
      chain_d    = out_data_d;
    end else begin
      // Decrypt: swapped key order, unwhiten after, input ciphertext feeds the chain.
      out_data_d = sdes_pkg::sdes_block(in_data_q, rk_q.rk_two, rk_q.rk_one) ^ prev_block;
      chain_d    = in_data_q;
    end
  end

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rk_q  <= sdes_pkg::RkReset;
      iv_q  <= sdes_pkg::IvReset;
      dir_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sdes_pkg::CFG_CIPHER_KEY:  rk_q  <= sdes_pkg::derive_keys(cfg_wdata_i);
        sdes_pkg::CFG_INIT_VECTOR: iv_q  <= cfg_wdata_i[7:0];
        sdes_pkg::CFG_DIRECTION:   dir_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Chain value advances with every item that reaches the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= sdes_pkg::IvReset;
    end else if (advance) begin
      chain_q <= chain_d;
    end
  end

  // Input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input stage payload; hold while the item waits.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q    <= s_axis_tdata;
      in_restart_q <= s_axis_tuser;
    end
  end

  // Result stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result stage payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Encrypt: the chain equals the ciphertext just placed in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !dir_q) |=> (chain_q == out_data_q))
    else $error("chain value differs from last ciphertext");

  // Decrypt: the chain equals the ciphertext byte just consumed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && dir_q) |=> (chain_q == $past(in_data_q)))
    else $error("chain value differs from last input ciphertext");

  // Backpressure only when both stages hold items and the sink stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a full pipeline");

endmodule

/* test/tb_sdes_cbc_cipher_unit.sv */
// Testbench for the S-DES CBC byte cipher: directed and random bytes checked against a CBC model.
module tb_sdes_cbc_cipher_unit;

  // Unused register index; a write there must leave every register alone.
  localparam logic [1:0] CfgNoReg = 2'd3;

  localparam logic [9:0] KeyAtReset = 10'd509;
  localparam logic [7:0] IvAtReset  = 8'd170;

  localparam int CycleLimit     = 200000;
  localparam int LongHoldCycles = 300;
  localparam int RandomRounds   = 12;
  localparam int BytesPerRound  = 110;

  // S-boxes, indexed [row][column].
  localparam logic [1:0] BoxZero [4][4] = '{
    '{2'd1, 2'd0, 2'd3, 2'd2}, '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd2, 2'd1, 2'd3}, '{2'd3, 2'd1, 2'd3, 2'd2}};
  localparam logic [1:0] BoxOne [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd1, 2'd0}, '{2'd2, 2'd1, 2'd0, 2'd3}};

  typedef struct packed {
    logic [7:0] data_block;
    logic       chain_restart;
  } cbc_byte_t;

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Configuration port.
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [9:0] cfg_wdata_i = '0;

  // Stream ports.
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;   // [7:0] data_block
  logic       s_axis_tuser  = 1'b0; // [0] chain_restart
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;         // [7:0] result_block

  // Local copy of the cipher state.
  logic [9:0] key_copy;
  logic [7:0] iv_copy;
  logic       decrypt_copy;
  logic [7:0] chain_copy;
  logic [7:0] rk_first;
  logic [7:0] rk_second;

  cbc_byte_t  byte_backlog [$];
  logic [7:0] cbc_out_due [$];
  cbc_byte_t  next_byte;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_req    = 1'b0;
  logic hold_done;
  int   hold_left;
  int   cycle_cnt   = 0;
  int   err_cnt     = 0;
  int   enc_cnt     = 0;
  int   dec_cnt     = 0;
  int   restart_cnt = 0;
  int   cfg_cnt     = 0;
  int   out_cnt     = 0;

  sdes_cbc_cipher_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // S-DES arithmetic. Permutations are written out as bit picks, positions
  // counted from 1 at the MSB and mapped to the LSB-based index width - pos.
  // ---------------------------------------------------------------------------
  function automatic logic [3:0] feistel_f(logic [3:0] half, logic [7:0] rk);
    logic [7:0] e;
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] s;
    // expand and permute the right nibble, then mix in the round key
    e = {half[0], half[3], half[2], half[1], half[2], half[1], half[0], half[3]} ^ rk;
    a = e[7:4];
    b = e[3:0];
    // outer bits pick the row, inner bits the column
    s = {BoxZero[{a[3], a[0]}][a[2:1]], BoxOne[{b[3], b[0]}][b[2:1]]};
    return {s[2], s[0], s[1], s[3]};
  endfunction

  function automatic logic [7:0] sdes_pass(logic [7:0] blk, logic [7:0] ka, logic [7:0] kb);
    logic [7:0] p;
    logic [3:0] nr;
    logic [3:0] nl;
    logic [7:0] f;
    p  = {blk[6], blk[2], blk[5], blk[7], blk[4], blk[0], blk[3], blk[1]};
    nr = p[7:4] ^ feistel_f(p[3:0], ka);
    // second round runs on the swapped halves; no swap after it
    nl = p[3:0] ^ feistel_f(nr, kb);
    f  = {nl, nr};
    return {f[4], f[7], f[5], f[3], f[1], f[6], f[0], f[2]};
  endfunction

  function automatic void load_key(logic [9:0] key);
    logic [9:0] p;
    logic [4:0] hi;
    logic [4:0] lo;
    logic [9:0] w;
    key_copy = key;
    p  = {key[7], key[5], key[8], key[3], key[6], key[0], key[9], key[1], key[2], key[4]};
    // rotate each half left by one
    hi = {p[8:5], p[9]};
    lo = {p[3:0], p[4]};
    w  = {hi, lo};
    rk_first = {w[4], w[7], w[3], w[6], w[2], w[5], w[0], w[1]};
    // then by two more
    hi = {hi[2:0], hi[4:3]};
    lo = {lo[2:0], lo[4:3]};
    w  = {hi, lo};
    rk_second = {w[4], w[7], w[3], w[6], w[2], w[5], w[0], w[1]};
  endfunction

  // One accepted byte: compute its result and advance the chain.
  function automatic void cbc_step(cbc_byte_t it);
    logic [7:0] prev;
    logic [7:0] res;
    prev = it.chain_restart ? iv_copy : chain_copy;
    if (it.chain_restart) restart_cnt++;
    if (!decrypt_copy) begin
      res        = sdes_pass(it.data_block ^ prev, rk_first, rk_second);
      chain_copy = res;
      enc_cnt++;
    end else begin
      // decryption uses the round keys swapped; the ciphertext feeds the chain
      res        = sdes_pass(it.data_block, rk_second, rk_first) ^ prev;
      chain_copy = it.data_block;
      dec_cnt++;
    end
    cbc_out_due.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer backlog bytes, predict on each slave-side transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        cbc_step('{data_block: s_axis_tdata, chain_restart: s_axis_tuser});
      end
      // hold a pending transfer; otherwise load the next byte or idle
      if (!s_axis_tvalid || s_axis_tready) begin
        if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_byte = byte_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_byte.data_block;
          s_axis_tuser  <= next_byte.chain_restart;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each master-side transfer against the oldest prediction,
  // and apply random back-pressure plus one long hold on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_cnt++;
        if (cbc_out_due.size() == 0) begin
          $error("result_block: no byte pending, got %02h", m_axis_tdata);
          err_cnt++;
        end else if (cbc_out_due[0] !== m_axis_tdata) begin
          $error("result_block: expected %02h, got %02h", cbc_out_due[0], m_axis_tdata);
          err_cnt++;
          void'(cbc_out_due.pop_front());
        end else begin
          void'(cbc_out_due.pop_front());
        end
      end
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        // long stall: the pipeline fills and the slave side must back up
        hold_left     <= LongHoldCycles;
        hold_done     <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("sdes_cbc_cipher_unit verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequencing.
  // ---------------------------------------------------------------------------
  // Register write; the local copy is updated as the write is driven, before the DUT registers it. Only call when idle.
  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      sdes_pkg::CFG_CIPHER_KEY:  load_key(val);
      sdes_pkg::CFG_INIT_VECTOR: iv_copy = val[7:0];
      sdes_pkg::CFG_DIRECTION:   decrypt_copy = val[0];
      default: ;
    endcase
    cfg_cnt++;
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] data, input logic restart);
    byte_backlog.push_back('{data_block: data, chain_restart: restart});
  endtask

  // Wait for every queued byte to transfer and every result to arrive, plus pipeline slack.
  task automatic drain();
    while (byte_backlog.size() != 0 || s_axis_tvalid || cbc_out_due.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [9:0] val;
    key_copy     = KeyAtReset;
    iv_copy      = IvAtReset;
    decrypt_copy = 1'b0;
    chain_copy   = IvAtReset;
    load_key(KeyAtReset);
    send_idle_pct = 27;
    recv_idle_pct = 83;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: the chain starts from the reset IV even without a restart.
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h55, 1'b1);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h01, 1'b1);
    push_byte(8'h80, 1'b0);
    drain();

    // Zero key; IV written with excess bits set, so it must mask to all ones.
    write_reg(sdes_pkg::CFG_CIPHER_KEY, 10'h000);
    write_reg(sdes_pkg::CFG_INIT_VECTOR, 10'h3FF);
    end_writes();
    push_byte(8'h00, 1'b0);   // a key write keeps the chain
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7E, 1'b0);
    drain();

    // All-ones key, zero IV, decrypt set through a value with excess bits.
    write_reg(sdes_pkg::CFG_CIPHER_KEY, 10'h3FF);
    write_reg(sdes_pkg::CFG_INIT_VECTOR, 10'h300);
    write_reg(sdes_pkg::CFG_DIRECTION, 10'h3FF);
    write_reg(CfgNoReg, 10'h155);
    end_writes();
    push_byte(8'h00, 1'b0);   // direction change keeps the chain
    push_byte(8'hFF, 1'b1);
    push_byte(8'h3C, 1'b0);
    push_byte(8'hC3, 1'b1);
    push_byte(8'h00, 1'b0);
    drain();

    // IV write alone: no effect until the next restart. Then back to encrypt.
    write_reg(sdes_pkg::CFG_INIT_VECTOR, 10'h0A5);
    write_reg(CfgNoReg, 10'h2AA);
    end_writes();
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b1);
    drain();
    write_reg(sdes_pkg::CFG_DIRECTION, 10'h002);
    end_writes();
    push_byte(8'h56, 1'b0);
    push_byte(8'h78, 1'b1);
    drain();

    // Random rounds: new settings each round, then a stream of random bytes.
    for (int r = 0; r < RandomRounds; r++) begin
      if (r == RandomRounds / 3) begin
        send_idle_pct = 83;
        recv_idle_pct = 27;
      end else if (r == 2 * RandomRounds / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(1) == 1) begin
        val = ($urandom_range(3) == 0) ? {10{$urandom_range(1) == 1}} : 10'($urandom);
        write_reg(sdes_pkg::CFG_CIPHER_KEY, val);
      end
      if ($urandom_range(1) == 1) begin
        val = ($urandom_range(3) == 0) ? {10{$urandom_range(1) == 1}} : 10'($urandom);
        write_reg(sdes_pkg::CFG_INIT_VECTOR, val);
      end
      // flip direction on alternate rounds, sometimes with junk upper bits
      write_reg(sdes_pkg::CFG_DIRECTION, {9'($urandom), r[0]});
      if ($urandom_range(3) == 0) write_reg(CfgNoReg, 10'($urandom));
      end_writes();

      if (r == RandomRounds - 3) begin
        @(posedge clk_i);
        hold_req <= 1'b1;
      end
      for (int n = 0; n < BytesPerRound; n++) begin
        push_byte(8'($urandom), $urandom_range(9) == 0);
        // halfway through one round, stop sending until every result is back
        if (r == RandomRounds - 2 && n == BytesPerRound / 2) drain();
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (cbc_out_due.size() != 0) begin
      $error("result_block: %0d results never arrived", cbc_out_due.size());
      err_cnt++;
    end
    $display("Covered %0d encrypt and %0d decrypt bytes, %0d chain restarts, %0d checked results,",
             enc_cnt, dec_cnt, restart_cnt, out_cnt);
    $display("%0d register writes including ignored index and masked values, long output stall.",
             cfg_cnt);
    if (err_cnt == 0) begin
      $display("sdes_cbc_cipher_unit verification clean");
    end else begin
      $display("sdes_cbc_cipher_unit verification failed");
    end
    $finish;
  end

endmodule
